[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the square-wave sound channel.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hdl/sqw_pkg.sv]
// Package for the square-wave sound channel: event codes, register map,
// widths, constants and the duty / length lookup tables. No dependencies.
package sqw_pkg;

  localparam int PERIOD_W  = 11;
  localparam int LEN_W     = 8;
  localparam int VOL_W     = 4;
  localparam int STEP_W    = 3;
  localparam int SWDIV_W   = 3;
  localparam int LIDX_W    = 5;
  localparam int FUNC_W    = 3;
  localparam int REG_NUM   = 8;
  localparam int REG_IDX_W = $clog2(REG_NUM);
  localparam int CFG_AW    = REG_IDX_W + 2;
  localparam int CFG_DW    = 32;

  localparam logic [PERIOD_W-1:0] MIN_PERIOD = PERIOD_W'(8);
  localparam logic [VOL_W-1:0]    DECAY_TOP  = '1;
  localparam logic [STEP_W-1:0]   STEP_TOP   = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK    = 3'd0,
    FUNC_QUARTER = 3'd1,
    FUNC_HALF    = 3'd2,
    FUNC_NOTE    = 3'd3,
    FUNC_SWEEP   = 3'd4
  } func_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DUTY      = 3'd0,
    REG_VOLUME    = 3'd1,
    REG_CONST_VOL = 3'd2,
    REG_HALT_LOOP = 3'd3,
    REG_SW_EN     = 3'd4,
    REG_SW_PERIOD = 3'd5,
    REG_SW_NEGATE = 3'd6,
    REG_SW_SHIFT  = 3'd7
  } reg_idx_t;

  // Negate mode codes; code 3 acts like the extra-one subtract.
  localparam logic [1:0] NEG_ADD = 2'd0;

  function automatic logic duty_bit(input logic [1:0] sel, input logic [STEP_W-1:0] step);
    logic [7:0] pat;
    unique case (sel)
      2'd0: pat = 8'b0000_0010;
      2'd1: pat = 8'b0000_0110;
      2'd2: pat = 8'b0001_1110;
      2'd3: pat = 8'b1111_1001;
    endcase
    return pat[step];
  endfunction

  function automatic logic [LEN_W-1:0] length_lookup(input logic [LIDX_W-1:0] idx);
    logic [LEN_W-1:0] v;
    unique case (idx)
      5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;   5'd3:  v = 8'd2;
      5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;   5'd7:  v = 8'd6;
      5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;   5'd11: v = 8'd10;
      5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;   5'd15: v = 8'd14;
      5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;   5'd19: v = 8'd18;
      5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;   5'd23: v = 8'd22;
      5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;   5'd27: v = 8'd26;
      5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;   5'd31: v = 8'd30;
    endcase
    return v;
  endfunction

endpackage

[hdl/square_wave_sound_channel.sv]
// Top level of the square-wave sound channel: event decode, channel state
// and a one-deep result register. Depends on sqw_pkg and assert_macros.svh.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | func, period_value, length_index, channel_enabled
//  out     | out_valid / out_ready| level, sample_valid, muted, length_active
//  cfg     | APB write, pready=1  | 8 registers at byte address 4*i
//
// One event per clock while in_ready is high: state is updated and the result
// word registered at the edge that accepts the input word.
// in_ready is low only while a result word sits unaccepted in the output
// register; a new word is taken in the same cycle the old result leaves.
// rst_n is synchronous; it resets state (mute set), configuration registers and the output valid.
`include "assert_macros.svh"

module square_wave_sound_channel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sqw_pkg::FUNC_W-1:0]    in_func,
  input  logic [sqw_pkg::PERIOD_W-1:0]  in_period_value,
  input  logic [sqw_pkg::LIDX_W-1:0]    in_length_index,
  input  logic                          in_channel_enabled,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sqw_pkg::VOL_W-1:0]     out_level,
  output logic                          out_sample_valid,
  output logic                          out_muted,
  output logic                          out_length_active,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sqw_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [sqw_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [sqw_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import sqw_pkg::*;

  // configuration registers
  logic [1:0]         duty_r;
  logic [VOL_W-1:0]   volume_r;
  logic               const_vol_r;
  logic               halt_loop_r;
  logic               sw_en_r;
  logic [SWDIV_W-1:0] sw_period_r;
  logic [1:0]         sw_negate_r;
  logic [2:0]         sw_shift_r;

  // channel state
  logic [PERIOD_W-1:0] timer_count_r, timer_count_nxt;
  logic [PERIOD_W-1:0] timer_reload_r, timer_reload_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [LEN_W-1:0]    length_r, length_nxt;
  logic [VOL_W-1:0]    env_div_r, env_div_nxt;
  logic [VOL_W-1:0]    decay_r, decay_nxt;
  logic [VOL_W-1:0]    env_level_r, env_level_nxt;
  logic                env_start_r, env_start_nxt;
  logic [SWDIV_W-1:0]  sw_div_r, sw_div_nxt;
  logic                sw_reload_r, sw_reload_nxt;
  logic                mute_r, mute_nxt;

  // result register
  logic               out_valid_r;
  logic [VOL_W-1:0]   level_r, level_nxt;
  logic               sample_valid_r, sample_valid_nxt;
  logic               muted_r;
  logic               len_active_r;

  logic               in_fire;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // sweep target, 12 bits: bit 11 flags a target above the 11-bit range or a wrapped subtract
  logic [PERIOD_W-1:0] sw_change;
  logic [PERIOD_W:0]   sw_target;

  assign in_ready   = !out_valid_r || out_ready;
  assign in_fire    = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  assign out_valid         = out_valid_r;
  assign out_level         = level_r;
  assign out_sample_valid  = sample_valid_r;
  assign out_muted         = muted_r;
  assign out_length_active = len_active_r;

  always_comb begin
    unique case (cfg_idx)
      REG_DUTY:      cfg_prdata = CFG_DW'(duty_r);
      REG_VOLUME:    cfg_prdata = CFG_DW'(volume_r);
      REG_CONST_VOL: cfg_prdata = CFG_DW'(const_vol_r);
      REG_HALT_LOOP: cfg_prdata = CFG_DW'(halt_loop_r);
      REG_SW_EN:     cfg_prdata = CFG_DW'(sw_en_r);
      REG_SW_PERIOD: cfg_prdata = CFG_DW'(sw_period_r);
      REG_SW_NEGATE: cfg_prdata = CFG_DW'(sw_negate_r);
      REG_SW_SHIFT:  cfg_prdata = CFG_DW'(sw_shift_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r      <= '0;
      volume_r    <= '0;
      const_vol_r <= 1'b0;
      halt_loop_r <= 1'b0;
      sw_en_r     <= 1'b0;
      sw_period_r <= '0;
      sw_negate_r <= '0;
      sw_shift_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DUTY:      duty_r      <= cfg_pwdata[1:0];
        REG_VOLUME:    volume_r    <= cfg_pwdata[VOL_W-1:0];
        REG_CONST_VOL: const_vol_r <= cfg_pwdata[0];
        REG_HALT_LOOP: halt_loop_r <= cfg_pwdata[0];
        REG_SW_EN:     sw_en_r     <= cfg_pwdata[0];
        REG_SW_PERIOD: sw_period_r <= cfg_pwdata[SWDIV_W-1:0];
        REG_SW_NEGATE: sw_negate_r <= cfg_pwdata[1:0];
        REG_SW_SHIFT:  sw_shift_r  <= cfg_pwdata[2:0];
      endcase
    end
  end

  // change never exceeds the period, so subtract only wraps when the
  // change equals the period and the extra one is taken
  always_comb begin
    sw_change = timer_reload_r >> sw_shift_r;
    if (sw_negate_r == NEG_ADD) begin
      sw_target = {1'b0, timer_reload_r} + {1'b0, sw_change};
    end else begin
      sw_target = {1'b0, timer_reload_r} - {1'b0, sw_change}
                  - (PERIOD_W + 1)'(sw_negate_r[1]);
    end
  end

  always_comb begin
    timer_count_nxt  = timer_count_r;
    timer_reload_nxt = timer_reload_r;
    step_nxt         = step_r;
    length_nxt       = length_r;
    env_div_nxt      = env_div_r;
    decay_nxt        = decay_r;
    env_level_nxt    = env_level_r;
    env_start_nxt    = env_start_r;
    sw_div_nxt       = sw_div_r;
    sw_reload_nxt    = sw_reload_r;
    mute_nxt         = mute_r;
    level_nxt        = '0;
    sample_valid_nxt = 1'b0;

    unique case (in_func)
      FUNC_TICK: begin
        mute_nxt = (timer_reload_r < MIN_PERIOD) || sw_target[PERIOD_W]
                   || (length_r == '0);
        if (timer_count_r == '0) begin
          timer_count_nxt = timer_reload_r;
          step_nxt        = (step_r == '0) ? STEP_TOP : step_r - 1'b1;
        end else begin
          timer_count_nxt = timer_count_r - 1'b1;
        end
        level_nxt = (!mute_nxt && duty_bit(duty_r, step_nxt)) ? env_level_r : '0;
        sample_valid_nxt = 1'b1;
      end
      FUNC_QUARTER: begin
        if (env_start_r) begin
          env_start_nxt = 1'b0;
          decay_nxt     = DECAY_TOP;
          env_div_nxt   = volume_r;
        end else if (env_div_r == '0) begin
          env_div_nxt = volume_r;
          if (decay_r != '0) begin
            decay_nxt = decay_r - 1'b1;
          end else if (halt_loop_r) begin
            decay_nxt = DECAY_TOP;
          end
        end else begin
          env_div_nxt = env_div_r - 1'b1;
        end
        env_level_nxt = const_vol_r ? volume_r : decay_nxt;
      end
      FUNC_HALF: begin
        if (length_r != '0 && !halt_loop_r) begin
          length_nxt = length_r - 1'b1;
        end
        // sweep sees the mute flag left by the last timer tick
        if (sw_div_r == '0 && sw_en_r && sw_shift_r != '0 && !mute_r) begin
          timer_reload_nxt = sw_target[PERIOD_W-1:0];
        end
        if (sw_div_r == '0 || sw_reload_r) begin
          sw_div_nxt    = sw_period_r;
          sw_reload_nxt = 1'b0;
        end else begin
          sw_div_nxt = sw_div_r - 1'b1;
        end
      end
      FUNC_NOTE: begin
        timer_reload_nxt = in_period_value;
        env_start_nxt    = 1'b1;
        if (in_channel_enabled) begin
          length_nxt = length_lookup(in_length_index);
        end
      end
      FUNC_SWEEP: sw_reload_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_count_r  <= '0;
      timer_reload_r <= '0;
      step_r         <= '0;
      length_r       <= '0;
      env_div_r      <= '0;
      decay_r        <= '0;
      env_level_r    <= '0;
      env_start_r    <= 1'b0;
      sw_div_r       <= '0;
      sw_reload_r    <= 1'b0;
      mute_r         <= 1'b1;
    end else if (in_fire) begin
      timer_count_r  <= timer_count_nxt;
      timer_reload_r <= timer_reload_nxt;
      step_r         <= step_nxt;
      length_r       <= length_nxt;
      env_div_r      <= env_div_nxt;
      decay_r        <= decay_nxt;
      env_level_r    <= env_level_nxt;
      env_start_r    <= env_start_nxt;
      sw_div_r       <= sw_div_nxt;
      sw_reload_r    <= sw_reload_nxt;
      mute_r         <= mute_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      level_r        <= level_nxt;
      sample_valid_r <= sample_valid_nxt;
      muted_r        <= mute_nxt;
      len_active_r   <= (length_nxt != '0);
    end
  end

  `ASSERT_NEXT(a_fire_gives_word, clk, rst_n, in_fire,
               out_valid_r && (sample_valid_r == ($past(in_func) == FUNC_TICK)))
  `ASSERT_NOW(a_muted_sample_silent, clk, rst_n,
              out_valid_r && sample_valid_r && muted_r, level_r == '0)
  `ASSERT_NOW(a_live_sample_has_length, clk, rst_n,
              out_valid_r && sample_valid_r && !muted_r, len_active_r)

endmodule

[tb/sqw_checker.sv]
// Output checker for the square-wave sound channel: follows register writes,
// predicts one output word per accepted input word and compares in order.
// Depends on sqw_pkg for port widths and the event and register codes.
module sqw_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [sqw_pkg::FUNC_W-1:0]   in_func,
  input  logic [sqw_pkg::PERIOD_W-1:0] in_period_value,
  input  logic [sqw_pkg::LIDX_W-1:0]   in_length_index,
  input  logic                         in_channel_enabled,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [sqw_pkg::VOL_W-1:0]    out_level,
  input  logic                         out_sample_valid,
  input  logic                         out_muted,
  input  logic                         out_length_active,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sqw_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [sqw_pkg::CFG_DW-1:0]   cfg_pwdata,
  input  logic                         cfg_pready,
  output int                           mismatches,
  output int                           pending,
  output int                           results_checked,
  output int                           loud_samples
);

  localparam logic [1:0]  SWEEP_ADD    = 2'd0;
  localparam logic [1:0]  SWEEP_SUB    = 2'd1;
  localparam logic [15:0] PERIOD_LIMIT = 16'h07FF;
  localparam logic [sqw_pkg::PERIOD_W-1:0] SHORTEST_PERIOD = 11'd8;
  localparam logic [sqw_pkg::VOL_W-1:0]    ENV_TOP = 4'd15;
  localparam int MAX_REPORTS = 40;

  // bit n of a pattern is the duty output at sequencer position n
  localparam logic [3:0][7:0] DUTY_WAVE = {
    8'b1111_1001, 8'b0001_1110, 8'b0000_0110, 8'b0000_0010
  };
  // listed from index 31 down to index 0
  localparam logic [31:0][7:0] NOTE_LENGTHS = {
    8'd30, 8'd32, 8'd28, 8'd16, 8'd26, 8'd72, 8'd24, 8'd192,
    8'd22, 8'd96, 8'd20, 8'd48, 8'd18, 8'd24, 8'd16, 8'd12,
    8'd14, 8'd26, 8'd12, 8'd14, 8'd10, 8'd60, 8'd8,  8'd160,
    8'd6,  8'd80, 8'd4,  8'd40, 8'd2,  8'd20, 8'd254, 8'd10
  };

  typedef struct packed {
    logic [sqw_pkg::VOL_W-1:0] level;
    logic                      sample_valid;
    logic                      muted;
    logic                      length_active;
  } chan_word_t;

  // register copy
  logic [1:0]                 duty_sel;
  logic [sqw_pkg::VOL_W-1:0]  vol_period;
  logic                       const_vol;
  logic                       halt_loop;
  logic                       sw_en;
  logic [2:0]                 sw_period;
  logic [1:0]                 sw_negate;
  logic [2:0]                 sw_shift;

  // channel state
  logic [sqw_pkg::PERIOD_W-1:0] tmr_cnt;
  logic [sqw_pkg::PERIOD_W-1:0] cur_period;
  logic [sqw_pkg::STEP_W-1:0]   seq_pos;
  logic [sqw_pkg::LEN_W-1:0]    len_count;
  logic [sqw_pkg::VOL_W-1:0]    env_div;
  logic [sqw_pkg::VOL_W-1:0]    env_decay;
  logic [sqw_pkg::VOL_W-1:0]    env_out;
  logic                         env_restart;
  logic [sqw_pkg::SWDIV_W-1:0]  sw_div;
  logic                         sw_restart;
  logic                         mute_now;

  chan_word_t predicted_outputs[$];

  function automatic void reset_channel();
    duty_sel    = '0;
    vol_period  = '0;
    const_vol   = 1'b0;
    halt_loop   = 1'b0;
    sw_en       = 1'b0;
    sw_period   = '0;
    sw_negate   = SWEEP_ADD;
    sw_shift    = '0;
    tmr_cnt     = '0;
    cur_period  = '0;
    seq_pos     = '0;
    len_count   = '0;
    env_div     = '0;
    env_decay   = '0;
    env_out     = '0;
    env_restart = 1'b0;
    sw_div      = '0;
    sw_restart  = 1'b0;
    mute_now    = 1'b1;
  endfunction

  function automatic void write_register(input logic [sqw_pkg::REG_IDX_W-1:0] idx,
                                         input logic [sqw_pkg::CFG_DW-1:0] data);
    case (idx)
      sqw_pkg::REG_DUTY:      duty_sel   = data[1:0];
      sqw_pkg::REG_VOLUME:    vol_period = data[3:0];
      sqw_pkg::REG_CONST_VOL: const_vol  = data[0];
      sqw_pkg::REG_HALT_LOOP: halt_loop  = data[0];
      sqw_pkg::REG_SW_EN:     sw_en      = data[0];
      sqw_pkg::REG_SW_PERIOD: sw_period  = data[2:0];
      sqw_pkg::REG_SW_NEGATE: sw_negate  = data[1:0];
      sqw_pkg::REG_SW_SHIFT:  sw_shift   = data[2:0];
      default: ;
    endcase
  endfunction

  // 16-bit sweep target; both subtract codes above the plain one take the extra 1
  function automatic logic [15:0] sweep_goal();
    logic [15:0] base;
    logic [15:0] delta;
    base  = 16'(cur_period);
    delta = base >> sw_shift;
    if (sw_negate == SWEEP_ADD) return base + delta;
    if (delta > base) return '0;
    return base - delta - ((sw_negate == SWEEP_SUB) ? 16'd0 : 16'd1);
  endfunction

  function automatic void clock_envelope();
    if (env_restart) begin
      env_restart = 1'b0;
      env_decay   = ENV_TOP;
      env_div     = vol_period;
    end else if (env_div == '0) begin
      env_div = vol_period;
      if (env_decay != '0) env_decay = env_decay - 1'b1;
      else if (halt_loop) env_decay = ENV_TOP;
    end else begin
      env_div = env_div - 1'b1;
    end
    env_out = const_vol ? vol_period : env_decay;
  endfunction

  function automatic void clock_half();
    logic [15:0] goal;
    if (len_count != '0 && !halt_loop) len_count = len_count - 1'b1;
    // the sweep looks at the mute flag left by the last tick
    if (sw_div == '0 && sw_en && sw_shift != '0 && !mute_now) begin
      goal       = sweep_goal();
      cur_period = goal[sqw_pkg::PERIOD_W-1:0];
    end
    if (sw_div == '0 || sw_restart) begin
      sw_div     = sw_period;
      sw_restart = 1'b0;
    end else begin
      sw_div = sw_div - 1'b1;
    end
  endfunction

  function automatic chan_word_t apply_event(input logic [sqw_pkg::FUNC_W-1:0] code,
                                             input logic [sqw_pkg::PERIOD_W-1:0] per,
                                             input logic [sqw_pkg::LIDX_W-1:0] idx,
                                             input logic en);
    chan_word_t w;
    w = '0;
    case (code)
      sqw_pkg::FUNC_TICK: begin
        mute_now = (cur_period < SHORTEST_PERIOD) || (sweep_goal() > PERIOD_LIMIT)
                   || (len_count == '0);
        if (tmr_cnt == '0) begin
          tmr_cnt = cur_period;
          seq_pos = seq_pos - 1'b1;
        end else begin
          tmr_cnt = tmr_cnt - 1'b1;
        end
        if (!mute_now && DUTY_WAVE[duty_sel][seq_pos]) w.level = env_out;
        w.sample_valid = 1'b1;
      end
      sqw_pkg::FUNC_QUARTER: clock_envelope();
      sqw_pkg::FUNC_HALF:    clock_half();
      sqw_pkg::FUNC_NOTE: begin
        cur_period  = per;
        env_restart = 1'b1;
        if (en) len_count = NOTE_LENGTHS[idx];
      end
      sqw_pkg::FUNC_SWEEP: sw_restart = 1'b1;
      default: ;
    endcase
    w.muted         = mute_now;
    w.length_active = (len_count != '0);
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [3:0] got,
                             input logic [3:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s on output word %0d: got %0h, expected %0h",
                                name, results_checked, got, want));
  endtask

  always @(posedge clk) begin : monitor
    chan_word_t want;
    if (!rst_n) begin
      reset_channel();
      predicted_outputs.delete();
      mismatches      = 0;
      results_checked = 0;
      loud_samples    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_outputs.size() == 0) begin
          report_mismatch($sformatf("output word with nothing predicted (level %0h)",
                                    out_level));
        end else begin
          want = predicted_outputs.pop_front();
          check_field("level", out_level, want.level);
          check_field("sample_valid", 4'(out_sample_valid), 4'(want.sample_valid));
          check_field("muted", 4'(out_muted), 4'(want.muted));
          check_field("length_active", 4'(out_length_active), 4'(want.length_active));
          if (want.sample_valid && want.level != '0) loud_samples++;
          results_checked++;
        end
      end
      if (in_valid && in_ready)
        predicted_outputs.push_back(apply_event(in_func, in_period_value,
                                                in_length_index, in_channel_enabled));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        write_register(cfg_paddr[sqw_pkg::CFG_AW-1:2], cfg_pwdata);
    end
    pending = predicted_outputs.size();
  end

endmodule

[tb/testbench.sv]
// Top of the square-wave sound channel testbench: clock, reset, register
// writes, input words and output back-pressure, and the final verdict.
// Depends on sqw_pkg, square_wave_sound_channel and sqw_checker.
module testbench;
  import sqw_pkg::*;

  localparam int LONG_HOLD       = 300;
  localparam int WORDS_PER_PHASE = 112;
  localparam int PHASES          = 8;
  localparam int DRAIN_LIMIT     = 2000;

  localparam logic [1:0] SWEEP_ADD     = 2'd0;
  localparam logic [1:0] SWEEP_SUB_ONE = 2'd2;
  localparam logic [1:0] SWEEP_ALIAS   = 2'd3;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [1:0]       duty;
    logic [VOL_W-1:0] volume;
    logic             const_vol;
    logic             halt_loop;
    logic             sw_en;
    logic [2:0]       sw_period;
    logic [1:0]       sw_negate;
    logic [2:0]       sw_shift;
  } channel_setting_t;

  logic                clk                = 1'b0;
  logic                rst_n              = 1'b0;
  logic                in_valid           = 1'b0;
  logic [FUNC_W-1:0]   in_func            = '0;
  logic [PERIOD_W-1:0] in_period_value    = '0;
  logic [LIDX_W-1:0]   in_length_index    = '0;
  logic                in_channel_enabled = 1'b0;
  logic                out_ready          = 1'b1;
  logic                cfg_psel           = 1'b0;
  logic                cfg_penable        = 1'b0;
  logic                cfg_pwrite         = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr          = '0;
  logic [CFG_DW-1:0]   cfg_pwdata         = '0;

  logic                in_ready;
  logic                out_valid;
  logic [VOL_W-1:0]    out_level;
  logic                out_sample_valid;
  logic                out_muted;
  logic                out_length_active;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  int mismatches;
  int pending;
  int results_checked;
  int loud_samples;
  int words_sent     = 0;
  int settings_used  = 0;
  logic idle_on      = 1'b1;
  logic hold_off_req = 1'b0;

  square_wave_sound_channel dut (.*);
  sqw_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timed out with %0d output words outstanding", pending);
    $display("testbench: FAIL");
    $finish;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [FUNC_W-1:0] code, input logic [PERIOD_W-1:0] per,
                           input logic [LIDX_W-1:0] idx, input logic en);
    in_valid           <= 1'b1;
    in_func            <= code;
    in_period_value    <= per;
    in_length_index    <= idx;
    in_channel_enabled <= en;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // payload fields other than the code are don't-care but still random
  task automatic send_code(input logic [FUNC_W-1:0] code);
    send_word(code, PERIOD_W'($urandom_range(0, 2047)), LIDX_W'($urandom_range(0, 31)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_random_word();
    int pick;
    int span;
    logic [FUNC_W-1:0]   code;
    logic [PERIOD_W-1:0] per;
    pick = $urandom_range(0, 99);
    if (pick < 50)      code = FUNC_TICK;
    else if (pick < 62) code = FUNC_QUARTER;
    else if (pick < 73) code = FUNC_HALF;
    else if (pick < 86) code = FUNC_NOTE;
    else if (pick < 95) code = FUNC_SWEEP;
    else code = FUNC_W'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
    // short periods keep the sequencer moving; long ones reach sweep overflow
    span = $urandom_range(0, 99);
    if (span < 15)      per = PERIOD_W'($urandom_range(0, 7));
    else if (span < 75) per = PERIOD_W'($urandom_range(8, 15));
    else if (span < 88) per = PERIOD_W'($urandom_range(16, 255));
    else                per = PERIOD_W'($urandom_range(0, 2047));
    send_word(code, per, LIDX_W'($urandom_range(0, 31)), $urandom_range(0, 5) != 0);
  endtask

  // back-to-back writes go straight from access to the next setup
  task automatic cfg_write(input reg_idx_t idx, input logic [VOL_W-1:0] val);
    logic [CFG_DW-1:0] data;
    data = $urandom;
    data[VOL_W-1:0] = val;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic apply_setting(input channel_setting_t s);
    cfg_write(REG_DUTY, VOL_W'(s.duty));
    cfg_write(REG_VOLUME, s.volume);
    cfg_write(REG_CONST_VOL, VOL_W'(s.const_vol));
    cfg_write(REG_HALT_LOOP, VOL_W'(s.halt_loop));
    cfg_write(REG_SW_EN, VOL_W'(s.sw_en));
    cfg_write(REG_SW_PERIOD, VOL_W'(s.sw_period));
    cfg_write(REG_SW_NEGATE, VOL_W'(s.sw_negate));
    cfg_write(REG_SW_SHIFT, VOL_W'(s.sw_shift));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    settings_used++;
  endtask

  function automatic channel_setting_t random_setting();
    channel_setting_t s;
    s.duty      = 2'($urandom_range(0, 3));
    s.volume    = 4'($urandom_range(0, 15));
    s.const_vol = 1'($urandom_range(0, 1));
    s.halt_loop = 1'($urandom_range(0, 1));
    s.sw_en     = 1'($urandom_range(0, 1));
    s.sw_period = 3'($urandom_range(0, 7));
    s.sw_negate = 2'($urandom_range(0, 3));
    s.sw_shift  = 3'($urandom_range(0, 7));
    return s;
  endfunction

  // hold off register writes until every predicted word has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  initial begin : stimulus
    channel_setting_t s;
    int ph;
    int n;
    int guard;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_setting('{2'd2, 4'd9, 1'b0, 1'b0, 1'b1, 3'd1, SWEEP_ADD, 3'd1});
    send_code(FUNC_TICK);                        // period still zero: muted
    send_code(FUNC_UNUSED_FIRST);
    send_code(FUNC_UNUSED_LAST);
    send_word(FUNC_NOTE, 11'h7FF, 5'd1, 1'b1);   // longest length, sweep overflow
    send_code(FUNC_TICK);
    send_word(FUNC_NOTE, 11'd7, 5'd31, 1'b0);    // disabled: length kept, short period
    send_code(FUNC_TICK);
    send_word(FUNC_NOTE, 11'd8, 5'd3, 1'b1);     // shortest audible period, length 2
    send_code(FUNC_QUARTER);
    send_code(FUNC_QUARTER);
    send_code(FUNC_TICK);
    send_code(FUNC_SWEEP);
    send_code(FUNC_HALF);
    repeat (4) send_code(FUNC_TICK);
    send_code(FUNC_HALF);                        // length runs out
    send_code(FUNC_TICK);
    send_word(FUNC_NOTE, 11'd0, 5'd0, 1'b1);
    send_code(FUNC_TICK);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       s = '{2'd3, 4'd15, 1'b1, 1'b1, 1'b1, 3'd7, SWEEP_ALIAS, 3'd7};
        1:       s = '0;
        2:       s = '{2'd1, 4'd2, 1'b0, 1'b1, 1'b1, 3'd0, SWEEP_SUB_ONE, 3'd1};
        default: s = random_setting();
      endcase
      apply_setting(s);
      idle_on = (ph < PHASES - 2) && (ph != 2);
      if (ph == 4) hold_off_req = 1'b1;
      for (n = 0; n < WORDS_PER_PHASE; n++) send_random_word();
    end

    in_valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < DRAIN_LIMIT);
    repeat (4) @(posedge clk);
    if (pending != 0) $display("%0d predicted output words never came out", pending);
    $display("run covered %0d input words under %0d register settings, one %0d-cycle hold-off",
             words_sent, settings_used, LONG_HOLD);
    $display("%0d output words checked, %0d of them nonzero samples, %0d mismatches",
             results_checked, loud_samples, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
